// File: sv/nsd_pkg.sv
// Shared types, codes and helpers of the NMEA sentence deframer.
`default_nettype none

package nsd_pkg;

    // Default buffer bounds
    localparam int COMMAND_BYTES_DEF = 8;
    localparam int DATA_BYTES_DEF    = 256;

    // Framing characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    // Per-byte classification
    typedef enum logic [3:0] {
        ST_IGNORED   = 4'd0,
        ST_START     = 4'd1,
        ST_CMD_BYTE  = 4'd2,
        ST_CMD_END   = 4'd3,
        ST_DATA_BYTE = 4'd4,
        ST_STAR      = 4'd5,
        ST_HEX1      = 4'd6,
        ST_OK        = 4'd7,
        ST_OK_NO_CHK = 4'd8,
        ST_DROPPED   = 4'd9
    } t_status;

    // Reason for a dropped sentence
    typedef enum logic [1:0] {
        DC_NONE     = 2'd0,
        DC_MISMATCH = 2'd1,
        DC_OVERFLOW = 2'd2
    } t_cause;

    // One result item
    typedef struct packed {
        logic [7:0] echo_byte;
        t_status    byte_status;
        t_cause     drop_cause;
        logic [7:0] position;
        logic [7:0] computed_checksum;
        logic [7:0] received_checksum;
    } t_result;

    // Reduce a hex digit to 4 bits; letters of either case map to 10..15
    function automatic logic [3:0] hex_nibble(input logic [7:0] b);
        logic [7:0] d;
        d = b - CH_ZERO;
        if (d <= 8'd9) begin
            return d[3:0];
        end
        // b - 'A' + 10 modulo 16 is b + 9 modulo 16
        return b[3:0] + 4'd9;
    endfunction

endpackage

`default_nettype wire

// File: sv/nsd_core.sv
// Sentence framing state machine, running checksum and per-byte classification.
`default_nettype none

module nsd_core #(
    parameter int COMMAND_BYTES = nsd_pkg::COMMAND_BYTES_DEF,
    parameter int DATA_BYTES    = nsd_pkg::DATA_BYTES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_advance,
    input  wire logic [7:0]       i_byte,
    output nsd_pkg::t_result      o_result
);

    localparam int MAX_BYTES = (COMMAND_BYTES > DATA_BYTES) ? COMMAND_BYTES : DATA_BYTES;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_CMD  = 3'd1,
        PH_DATA = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [7:0]         r_xor, n_xor;
    logic [7:0]         r_chk, n_chk;
    logic [CNT_W-1:0]   count_inc;

    assign count_inc = r_count + CNT_W'(1);

    // Classify the byte and work out the next framing state
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_xor    = r_xor;
        n_chk    = r_chk;
        o_result.echo_byte   = i_byte;
        o_result.byte_status = nsd_pkg::ST_IGNORED;
        o_result.drop_cause  = nsd_pkg::DC_NONE;
        o_result.position    = 8'd0;

        unique case (r_phase)
            PH_CMD: begin
                n_xor = r_xor ^ i_byte;
                if (i_byte != nsd_pkg::CH_COMMA && i_byte != nsd_pkg::CH_STAR) begin
                    o_result.position = 8'(r_count);
                    n_count = count_inc;
                    if (count_inc >= CNT_W'(COMMAND_BYTES)) begin
                        o_result.byte_status = nsd_pkg::ST_DROPPED;
                        o_result.drop_cause  = nsd_pkg::DC_OVERFLOW;
                        n_phase = PH_HUNT;
                    end else begin
                        o_result.byte_status = nsd_pkg::ST_CMD_BYTE;
                    end
                end else begin
                    n_count = '0;
                    o_result.byte_status = nsd_pkg::ST_CMD_END;
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (i_byte == nsd_pkg::CH_STAR) begin
                    o_result.byte_status = nsd_pkg::ST_STAR;
                    n_phase = PH_HEX1;
                end else if (i_byte == nsd_pkg::CH_CR) begin
                    o_result.byte_status = nsd_pkg::ST_OK_NO_CHK;
                    n_phase = PH_HUNT;
                end else begin
                    n_xor = r_xor ^ i_byte;
                    o_result.position = 8'(r_count);
                    n_count = count_inc;
                    if (count_inc >= CNT_W'(DATA_BYTES)) begin
                        o_result.byte_status = nsd_pkg::ST_DROPPED;
                        o_result.drop_cause  = nsd_pkg::DC_OVERFLOW;
                        n_phase = PH_HUNT;
                    end else begin
                        o_result.byte_status = nsd_pkg::ST_DATA_BYTE;
                    end
                end
            end
            PH_HEX1: begin
                n_chk = {nsd_pkg::hex_nibble(i_byte), 4'd0};
                o_result.byte_status = nsd_pkg::ST_HEX1;
                n_phase = PH_HEX2;
            end
            PH_HEX2: begin
                n_chk = {r_chk[7:4], nsd_pkg::hex_nibble(i_byte)};
                if (n_chk == r_xor) begin
                    o_result.byte_status = nsd_pkg::ST_OK;
                end else begin
                    o_result.byte_status = nsd_pkg::ST_DROPPED;
                    o_result.drop_cause  = nsd_pkg::DC_MISMATCH;
                end
                n_phase = PH_HUNT;
            end
            default: begin
                // Hunt for the start of a sentence; unused codes land here too
                n_phase = PH_HUNT;
                if (i_byte == nsd_pkg::CH_DOLLAR) begin
                    n_xor   = 8'd0;
                    n_count = '0;
                    n_chk   = 8'd0;
                    o_result.byte_status = nsd_pkg::ST_START;
                    n_phase = PH_CMD;
                end
            end
        endcase

        o_result.computed_checksum = n_xor;
        o_result.received_checksum = n_chk;
    end

    // Hold framing state; advance once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
            r_xor   <= 8'd0;
            r_chk   <= 8'd0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_xor   <= n_xor;
            r_chk   <= n_chk;
        end
    end

endmodule

`default_nettype wire

// File: sv/nmea_sentence_deframer.sv
// Top level of the NMEA sentence deframer: input register, core and result register.
`default_nettype none

// Takes one received character per item and returns one status item per
// character: start, command or data byte with its buffer position, separator,
// checksum digits, and the sentence verdict (accepted with or without checksum,
// or dropped on checksum mismatch or buffer overflow) together with the running
// XOR checksum and the decoded received checksum. The block sustains one item
// per clock cycle while the result register is free or being taken; each item
// passes through an input register and then the result register, which holds
// it until taken. The single framing state update per cycle in the core sets
// that rate. COMMAND_BYTES and DATA_BYTES bound the command and data buffers.
module nmea_sentence_deframer #(
    parameter int COMMAND_BYTES = nsd_pkg::COMMAND_BYTES_DEF,
    parameter int DATA_BYTES    = nsd_pkg::DATA_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_rx_valid,
    output logic            o_rx_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_res_valid,
    input  wire logic       i_res_stall,
    output logic [7:0]      o_echo_byte,
    output logic [3:0]      o_byte_status,
    output logic [1:0]      o_drop_cause,
    output logic [7:0]      o_position,
    output logic [7:0]      o_computed_checksum,
    output logic [7:0]      o_received_checksum
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_out_valid;
    nsd_pkg::t_result   r_out;
    nsd_pkg::t_result   core_result;
    logic               advance;

    // Process the held item when the result register is free or being taken
    assign advance    = r_in_valid && (!r_out_valid || !i_res_stall);
    assign o_rx_stall = r_in_valid && !advance;

    nsd_core #(
        .COMMAND_BYTES (COMMAND_BYTES),
        .DATA_BYTES    (DATA_BYTES)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .o_result  (core_result)
    );

    // Capture incoming items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_rx_stall) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_valid && !o_rx_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Hold results until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_res_valid         = r_out_valid;
    assign o_echo_byte         = r_out.echo_byte;
    assign o_byte_status       = r_out.byte_status;
    assign o_drop_cause        = r_out.drop_cause;
    assign o_position          = r_out.position;
    assign o_computed_checksum = r_out.computed_checksum;
    assign o_received_checksum = r_out.received_checksum;

    // A drop cause is given exactly for dropped sentences
    a_cause_matches_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> ((o_byte_status == nsd_pkg::ST_DROPPED) ==
                         (o_drop_cause != nsd_pkg::DC_NONE)))
        else $error("drop cause does not match dropped status");

    // A checked sentence is accepted only when both checksums agree
    a_ok_means_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_byte_status == nsd_pkg::ST_OK) |->
            (o_computed_checksum == o_received_checksum))
        else $error("sentence accepted with checksum mismatch");

    // Positions are reported only for buffered bytes
    a_position_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_position != 8'd0) |->
            (o_byte_status == nsd_pkg::ST_CMD_BYTE ||
             o_byte_status == nsd_pkg::ST_DATA_BYTE ||
             o_byte_status == nsd_pkg::ST_DROPPED))
        else $error("position set on a byte outside a buffer");

endmodule

`default_nettype wire

// File: verif/nsd_status_checker.sv
`timescale 1ns / 100ps
// Status checker of the NMEA sentence deframer: tracks the framing, predicts and compares items.
module nsd_status_checker #(
    parameter int COMMAND_BYTES = nsd_pkg::COMMAND_BYTES_DEF,
    parameter int DATA_BYTES    = nsd_pkg::DATA_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_rx_valid,
    input  wire logic       i_rx_stall,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_res_valid,
    input  wire logic       i_res_stall,
    input  wire logic [7:0] i_echo_byte,
    input  wire logic [3:0] i_byte_status,
    input  wire logic [1:0] i_drop_cause,
    input  wire logic [7:0] i_position,
    input  wire logic [7:0] i_computed_checksum,
    input  wire logic [7:0] i_received_checksum,
    output int              o_outstanding,
    output int              o_mismatches
);

    import nsd_pkg::*;

    // Framing phases of the sentence tracker
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_CMD,
        PH_DATA,
        PH_CHK_HI,
        PH_CHK_LO
    } t_phase;

    t_phase     phase;
    logic [8:0] fill;
    logic [7:0] sum_xor;
    logic [7:0] chk_rx;

    t_result pending_status[$];
    int      results_seen;

    initial o_mismatches = 0;

    // Value of a checksum digit; anything not decimal is taken as a letter
    function automatic logic [3:0] digit_value(input logic [7:0] b);
        logic [7:0] off;
        off = b - 8'h30;
        if (off < 8'd10) begin
            return off[3:0];
        end
        return b[3:0] - 4'd7;
    endfunction

    // Advance the framing state by one byte and return its status item
    function automatic t_result deframe_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        r.echo_byte   = b;
        r.byte_status = ST_IGNORED;
        r.drop_cause  = DC_NONE;
        case (phase)
            PH_CMD: begin
                sum_xor = sum_xor ^ b;
                if (b != CH_COMMA && b != CH_STAR) begin
                    r.position = fill[7:0];
                    fill = fill + 9'd1;
                    if (fill >= COMMAND_BYTES) begin
                        r.byte_status = ST_DROPPED;
                        r.drop_cause  = DC_OVERFLOW;
                        phase = PH_HUNT;
                    end else begin
                        r.byte_status = ST_CMD_BYTE;
                    end
                end else begin
                    fill = '0;
                    r.byte_status = ST_CMD_END;
                    phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (b == CH_STAR) begin
                    r.byte_status = ST_STAR;
                    phase = PH_CHK_HI;
                end else if (b == CH_CR) begin
                    r.byte_status = ST_OK_NO_CHK;
                    phase = PH_HUNT;
                end else begin
                    sum_xor = sum_xor ^ b;
                    r.position = fill[7:0];
                    fill = fill + 9'd1;
                    if (fill >= DATA_BYTES) begin
                        r.byte_status = ST_DROPPED;
                        r.drop_cause  = DC_OVERFLOW;
                        phase = PH_HUNT;
                    end else begin
                        r.byte_status = ST_DATA_BYTE;
                    end
                end
            end
            PH_CHK_HI: begin
                chk_rx = {digit_value(b), 4'h0};
                r.byte_status = ST_HEX1;
                phase = PH_CHK_LO;
            end
            PH_CHK_LO: begin
                chk_rx[3:0] = digit_value(b);
                if (chk_rx == sum_xor) begin
                    r.byte_status = ST_OK;
                end else begin
                    r.byte_status = ST_DROPPED;
                    r.drop_cause  = DC_MISMATCH;
                end
                phase = PH_HUNT;
            end
            default: begin
                phase = PH_HUNT;
                if (b == CH_DOLLAR) begin
                    sum_xor = '0;
                    fill    = '0;
                    chk_rx  = '0;
                    r.byte_status = ST_START;
                    phase = PH_CMD;
                end
            end
        endcase
        r.computed_checksum = sum_xor;
        r.received_checksum = chk_rx;
        return r;
    endfunction

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        o_mismatches++;
        $display("%0t ns: item %0d, %s expected %02h got %02h",
                 $time, results_seen, what, want, got);
    endtask

    // Compare each delivered item with the oldest prediction, then queue new ones
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            fill    = '0;
            sum_xor = '0;
            chk_rx  = '0;
            phase   = PH_HUNT;
            pending_status.delete();
            results_seen = 0;
            o_outstanding <= 0;
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (pending_status.size() == 0) begin
                    report_mismatch("unexpected item, echo_byte", 8'h00, i_echo_byte);
                end else begin
                    want = pending_status.pop_front();
                    if (i_echo_byte !== want.echo_byte)
                        report_mismatch("echo_byte", want.echo_byte, i_echo_byte);
                    if (i_byte_status !== want.byte_status)
                        report_mismatch("byte_status", 8'(want.byte_status),
                                        8'(i_byte_status));
                    if (i_drop_cause !== want.drop_cause)
                        report_mismatch("drop_cause", 8'(want.drop_cause),
                                        8'(i_drop_cause));
                    if (i_position !== want.position)
                        report_mismatch("position", want.position, i_position);
                    if (i_computed_checksum !== want.computed_checksum)
                        report_mismatch("computed_checksum", want.computed_checksum,
                                        i_computed_checksum);
                    if (i_received_checksum !== want.received_checksum)
                        report_mismatch("received_checksum", want.received_checksum,
                                        i_received_checksum);
                end
                results_seen++;
            end
            if (i_rx_valid && !i_rx_stall) begin
                pending_status.push_back(deframe_byte(i_rx_byte));
            end
            o_outstanding <= pending_status.size();
        end
    end

endmodule

// File: verif/tb_nmea_sentence_deframer.sv
`timescale 1ns / 100ps
// Testbench top of the NMEA sentence deframer: clock, reset, byte stream, receiver and verdict.
module tb_nmea_sentence_deframer;

    import nsd_pkg::*;

    localparam int CMD_MAX  = COMMAND_BYTES_DEF;
    localparam int DATA_MAX = DATA_BYTES_DEF;
    localparam int RANDOM_ITEMS = 525;

    // How a generated sentence is closed
    typedef enum logic [1:0] {
        END_CHECKED,
        END_CORRUPT,
        END_CR,
        END_TRUNCATED
    } t_ending;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_rx_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_res_stall = 1'b0;

    logic       o_rx_stall;
    logic       o_res_valid;
    logic [7:0] o_echo_byte;
    logic [3:0] o_byte_status;
    logic [1:0] o_drop_cause;
    logic [7:0] o_position;
    logic [7:0] o_computed_checksum;
    logic [7:0] o_received_checksum;

    int outstanding;
    int mismatches;

    int items_sent  = 0;
    bit tx_calm     = 1'b0;
    bit rx_calm     = 1'b0;
    int rx_hold_len = 0;

    always #6 i_clk = ~i_clk;

    nmea_sentence_deframer uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_rx_valid          (i_rx_valid),
        .o_rx_stall          (o_rx_stall),
        .i_rx_byte           (i_rx_byte),
        .o_res_valid         (o_res_valid),
        .i_res_stall         (i_res_stall),
        .o_echo_byte         (o_echo_byte),
        .o_byte_status       (o_byte_status),
        .o_drop_cause        (o_drop_cause),
        .o_position          (o_position),
        .o_computed_checksum (o_computed_checksum),
        .o_received_checksum (o_received_checksum)
    );

    nsd_status_checker #(
        .COMMAND_BYTES (CMD_MAX),
        .DATA_BYTES    (DATA_MAX)
    ) status_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_rx_valid          (i_rx_valid),
        .i_rx_stall          (o_rx_stall),
        .i_rx_byte           (i_rx_byte),
        .i_res_valid         (o_res_valid),
        .i_res_stall         (i_res_stall),
        .i_echo_byte         (o_echo_byte),
        .i_byte_status       (o_byte_status),
        .i_drop_cause        (o_drop_cause),
        .i_position          (o_position),
        .i_computed_checksum (o_computed_checksum),
        .i_received_checksum (o_received_checksum),
        .o_outstanding       (outstanding),
        .o_mismatches        (mismatches)
    );

    // Offer one byte after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_rx_stall);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        foreach (s[i]) send_byte(s[i]);
    endtask

    // Stop offering and wait until every predicted item has come back
    task automatic drain();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        wait (outstanding == 0);
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] any_byte_except(input logic [7:0] a, input logic [7:0] c);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == a || b == c);
        return b;
    endfunction

    // Checksum digit in either letter case
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        string upper_digits;
        string lower_digits;
        upper_digits = "0123456789ABCDEF";
        lower_digits = "0123456789abcdef";
        return $urandom_range(0, 1) ? upper_digits[nib] : lower_digits[nib];
    endfunction

    // Build one sentence with random content and send it
    task automatic send_sentence(input int cmd_len, input int data_len, input t_ending ending);
        logic [7:0] sum;
        logic [7:0] b;
        sum = 8'h00;
        send_byte(CH_DOLLAR);
        repeat (cmd_len) begin
            b = any_byte_except(CH_COMMA, CH_STAR);
            sum ^= b;
            send_byte(b);
        end
        b = $urandom_range(0, 1) ? CH_COMMA : CH_STAR;
        sum ^= b;
        send_byte(b);
        repeat (data_len) begin
            b = any_byte_except(CH_STAR, CH_CR);
            sum ^= b;
            send_byte(b);
        end
        case (ending)
            END_CHECKED: begin
                send_byte(CH_STAR);
                send_byte(hex_char(sum[7:4]));
                send_byte(hex_char(sum[3:0]));
            end
            END_CORRUPT: begin
                send_byte(CH_STAR);
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 255)));
            end
            END_CR: send_byte(CH_CR);
            default: ;
        endcase
    endtask

    // Receiver: stall a random number of cycles per item, or a long hold on request
    initial begin
        int n;
        forever begin
            if (rx_hold_len > 0) begin
                n = rx_hold_len;
                rx_hold_len = 0;
            end else begin
                n = rx_calm ? 0 : $urandom_range(0, 7);
            end
            if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
            if (n > 0) begin
                i_res_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_res_stall <= 1'b0;
            do @(posedge i_clk); while (!o_res_valid);
        end
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        int kind;
        int e;
        int mark;
        int progress;
        t_ending ending;
        bit hold_done;
        bit long_done;
        bit pause_done;
        hold_done  = 1'b0;
        long_done  = 1'b0;
        pause_done = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // noise before any sentence
        send_byte(8'h00);
        // star closes the command, lowercase checksum digits
        send_byte(CH_DOLLAR);
        send_text("A");
        send_byte(CH_STAR);
        send_byte(CH_STAR);
        send_text("6b");
        // carriage return and dollar inside the command, then no checksum
        send_byte(CH_DOLLAR);
        send_byte(CH_CR);
        send_byte(CH_DOLLAR);
        send_byte(CH_COMMA);
        send_byte(CH_CR);
        // empty command and a digit outside the hex range: mismatch
        send_byte(CH_DOLLAR);
        send_byte(CH_COMMA);
        send_byte(CH_STAR);
        send_text("0Z");
        // command overflow on all-ones bytes
        send_byte(CH_DOLLAR);
        repeat (CMD_MAX) send_byte(8'hFF);
        drain();

        mark = items_sent;
        progress = 0;
        while (progress < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                e = $urandom_range(0, 99);
                ending = (e < 55) ? END_CHECKED : (e < 70) ? END_CORRUPT :
                         (e < 92) ? END_CR : END_TRUNCATED;
                send_sentence(($urandom_range(0, 9) == 0) ? $urandom_range(CMD_MAX - 1, CMD_MAX + 1)
                                                          : $urandom_range(0, CMD_MAX - 2),
                              $urandom_range(0, 12), ending);
            end else if (kind < 90) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_byte(CH_DOLLAR);
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 5) == 0) tx_calm = !tx_calm;

            progress = items_sent - mark;
            // hold the receiver off while bytes keep coming, so the block backs up
            if (!hold_done && progress > 150) begin
                rx_hold_len = 120;
                tx_calm = 1'b1;
                repeat (3) send_sentence(4, 6, END_CHECKED);
                tx_calm = 1'b0;
                hold_done = 1'b1;
            end
            // data field that fills the buffer and overflows on its last byte
            if (!long_done && progress > 100) begin
                send_sentence(2, DATA_MAX, END_CR);
                long_done = 1'b1;
            end
            if (!pause_done && progress > 400) begin
                drain();
                pause_done = 1'b1;
            end
            progress = items_sent - mark;
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/nsd_pkg.sv
sv/nsd_core.sv
sv/nmea_sentence_deframer.sv
verif/nsd_status_checker.sv
verif/tb_nmea_sentence_deframer.sv
